// File: sv/cbr_pkg.sv
// Shared types, widths and codes of the cubic bisection root finder.
package cbr_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int TOL_W        = 16;
  localparam int CFG_ADDR_W   = 3;
  localparam int LIMB_W       = VALUE_WIDTH;
  localparam int ACC_W        = 4 * VALUE_WIDTH;
  localparam int HORNER_STEPS = 3;
  localparam int STEP_W       = $clog2(HORNER_STEPS);
  localparam int PROD_W       = LIMB_W + 1 + VALUE_WIDTH;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_CUBIC  = 3'd0,
    REG_COEF_SQUARE = 3'd1,
    REG_COEF_LINEAR = 3'd2,
    REG_COEF_CONST  = 3'd3,
    REG_WIDTH_TOL   = 3'd4,
    REG_ZERO_BAND   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_ZERO_HIT   = 2'd1,
    ST_NO_BRACKET = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] interval_low;
    logic signed [VALUE_WIDTH-1:0] interval_high;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] root;
    status_t                       status;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] coef_cubic;
    logic signed [VALUE_WIDTH-1:0] coef_square;
    logic signed [VALUE_WIDTH-1:0] coef_linear;
    logic signed [VALUE_WIDTH-1:0] coef_const;
    logic [TOL_W-1:0]              width_tolerance;
    logic [TOL_W-1:0]              zero_band;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic neg;
    logic zero;
  } eval_res_t;

endpackage

// File: sv/cbr_poly_eval.sv
// Horner evaluation of the cubic on one shared limb multiplier, sign and zero-band test.
module cbr_poly_eval import cbr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          eval_req,
  input  logic signed [VALUE_WIDTH-1:0] eval_x,
  input  cfg_t                          cfg,
  output eval_res_t                     res
);

  typedef enum logic [3:0] {
    P_IDLE  = 4'b0001,
    P_MUL   = 4'b0010,
    P_DRAIN = 4'b0100,
    P_CHECK = 4'b1000
  } pstate_t;

  pstate_t                       pstate;
  logic [STEP_W-1:0]             step;
  logic [STEP_W-1:0]             limb;
  logic [STEP_W-1:0]             pp_limb;
  logic                          pp_vld;
  logic signed [VALUE_WIDTH-1:0] x_reg;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       prod;
  logic signed [PROD_W-1:0]      pp;
  logic                          done;
  logic                          neg;
  logic                          zero;

  logic [LIMB_W-1:0]             limb_bits;
  logic signed [LIMB_W:0]        mul_a;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [ACC_W-1:0]       pp_shifted;
  logic signed [ACC_W-1:0]       band;
  logic signed [ACC_W-1:0]       band_neg;
  logic                          in_band;

  function automatic logic signed [ACC_W-1:0] sext_coef(logic signed [VALUE_WIDTH-1:0] c);
    return {{(ACC_W-VALUE_WIDTH){c[VALUE_WIDTH-1]}}, c};
  endfunction

  // Term added after Horner multiply s, already at the scale of the product.
  function automatic logic signed [ACC_W-1:0] coef_term(cfg_t c, logic [STEP_W-1:0] s);
    logic signed [ACC_W-1:0] t;
    t = '0;
    case (s)
      STEP_W'(0): t = sext_coef(c.coef_square) << FRAC_BITS;
      STEP_W'(1): t = sext_coef(c.coef_linear) << (2 * FRAC_BITS);
      default:    t = sext_coef(c.coef_const) << (3 * FRAC_BITS);
    endcase
    return t;
  endfunction

  // The top active limb of acc carries the sign, lower limbs are unsigned.
  assign limb_bits  = acc[limb*LIMB_W +: LIMB_W];
  assign mul_a      = {(limb == step) ? limb_bits[LIMB_W-1] : 1'b0, limb_bits};
  assign mul_p      = mul_a * x_reg;
  assign pp_shifted = {{(ACC_W-PROD_W){pp[PROD_W-1]}}, pp} << (LIMB_W * int'(pp_limb));

  assign band     = {{(ACC_W-TOL_W){1'b0}}, cfg.zero_band} << (3 * FRAC_BITS);
  assign band_neg = -band;
  assign in_band  = (acc <= band) && (acc >= band_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (pstate)
        P_IDLE: begin
          if (eval_req) begin
            x_reg  <= eval_x;
            acc    <= sext_coef(cfg.coef_cubic);
            prod   <= coef_term(cfg, STEP_W'(0));
            step   <= '0;
            limb   <= '0;
            pp_vld <= 1'b0;
            pstate <= P_MUL;
          end
        end
        P_MUL: begin
          pp      <= mul_p;
          pp_limb <= limb;
          pp_vld  <= 1'b1;
          if (pp_vld) begin
            prod <= prod + pp_shifted;
          end
          if (limb == step) begin
            pstate <= P_DRAIN;
          end else begin
            limb <= limb + STEP_W'(1);
          end
        end
        P_DRAIN: begin
          acc    <= prod + pp_shifted;
          pp_vld <= 1'b0;
          if (step == STEP_W'(HORNER_STEPS - 1)) begin
            pstate <= P_CHECK;
          end else begin
            step   <= step + STEP_W'(1);
            limb   <= '0;
            prod   <= coef_term(cfg, step + STEP_W'(1));
            pstate <= P_MUL;
          end
        end
        P_CHECK: begin
          done   <= 1'b1;
          neg    <= acc[ACC_W-1];
          zero   <= in_band;
          pstate <= P_IDLE;
        end
        default: pstate <= P_IDLE;
      endcase
    end
  end

  assign res.busy = (pstate != P_IDLE);
  assign res.done = done;
  assign res.neg  = neg;
  assign res.zero = zero;

endmodule

// File: sv/cubic_bisection_root_core.sv
// Bisection root finder for a configured cubic: sequencer, registers and result port.
//
// Usage: write the coefficients, width tolerance and zero band on the cfg_we/cfg_addr/
// cfg_data port while the block is idle; each register takes effect at the write edge.
// An item (interval ends in signed Q16.16) is taken at a clock edge with start high and
// busy low. busy stays high until the result is issued. The result (root, status) is
// marked by done, which is high for exactly one cycle; the receiver cannot stall, and start
// may be raised in the same cycle as done.
// Each evaluation of the cubic runs on one shared limb multiplier in cbr_poly_eval: its
// three Horner steps take 1, 2 and 3 limb products, each followed by a drain, and then a
// band check. The first halving evaluates both ends and the midpoint, every later halving
// only the midpoint, and each halving begins with a width test. A full 32-bit interval at
// the reset tolerance needs 26 halvings. An interval already within tolerance finishes at
// the width test with no evaluation.
// Reset returns the sequencer to idle, drops any item at work and sets the registers to
// their reset values (coefficients zero, tolerance 66, zero band zero).
module cubic_bisection_root_core import cbr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               operands,
  output logic                   done,
  output out_item_t              result,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [VALUE_WIDTH-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOP = 5'b00010,
    S_WHI  = 5'b00100,
    S_WLO  = 5'b01000,
    S_WMID = 5'b10000
  } state_t;

  state_t                        state;
  cfg_t                          cfg;
  logic signed [VALUE_WIDTH-1:0] lo;
  logic signed [VALUE_WIDTH-1:0] hi;
  logic                          first;
  logic                          fhi_neg;
  logic                          flo_neg;

  logic signed [VALUE_WIDTH:0]   diff;
  logic signed [VALUE_WIDTH:0]   sum;
  logic signed [VALUE_WIDTH:0]   tol_ext;
  logic [TOL_W-1:0]              tol_eff;
  logic signed [VALUE_WIDTH-1:0] mid;
  logic                          go;

  logic                          eval_req;
  logic signed [VALUE_WIDTH-1:0] eval_x;
  eval_res_t                     ev;

  assign tol_eff = (cfg.width_tolerance == '0) ? TOL_W'(1) : cfg.width_tolerance;
  assign tol_ext = {{(VALUE_WIDTH+1-TOL_W){1'b0}}, tol_eff};
  assign diff    = {hi[VALUE_WIDTH-1], hi} - {lo[VALUE_WIDTH-1], lo};
  assign sum     = {hi[VALUE_WIDTH-1], hi} + {lo[VALUE_WIDTH-1], lo};
  assign mid     = sum[VALUE_WIDTH:1];
  assign go      = (diff > tol_ext);
  assign busy    = (state != S_IDLE);

  // Kick the evaluator straight from the sequencer state.
  always_comb begin
    eval_req = 1'b0;
    eval_x   = mid;
    unique case (state)
      S_LOOP: begin
        eval_req = go;
        eval_x   = first ? hi : mid;
      end
      S_WHI: begin
        eval_req = ev.done && !ev.zero;
        eval_x   = lo;
      end
      S_WLO: begin
        eval_req = ev.done && !ev.zero && (ev.neg != fhi_neg);
        eval_x   = mid;
      end
      default: begin
        eval_req = 1'b0;
        eval_x   = mid;
      end
    endcase
  end

  cbr_poly_eval u_eval (
    .clk      (clk),
    .rst      (rst),
    .eval_req (eval_req),
    .eval_x   (eval_x),
    .cfg      (cfg),
    .res      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_cubic      <= '0;
      cfg.coef_square     <= '0;
      cfg.coef_linear     <= '0;
      cfg.coef_const      <= '0;
      cfg.width_tolerance <= TOL_RESET;
      cfg.zero_band       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEF_CUBIC:  cfg.coef_cubic      <= cfg_data;
        REG_COEF_SQUARE: cfg.coef_square     <= cfg_data;
        REG_COEF_LINEAR: cfg.coef_linear     <= cfg_data;
        REG_COEF_CONST:  cfg.coef_const      <= cfg_data;
        REG_WIDTH_TOL:   cfg.width_tolerance <= cfg_data[TOL_W-1:0];
        REG_ZERO_BAND:   cfg.zero_band       <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lo    <= operands.interval_low;
            hi    <= operands.interval_high;
            first <= 1'b1;
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (!go) begin
            done          <= 1'b1;
            result.root   <= lo;
            result.status <= ST_CONVERGED;
            state         <= S_IDLE;
          end else if (first) begin
            state <= S_WHI;
          end else begin
            state <= S_WMID;
          end
        end
        S_WHI: begin
          if (ev.done) begin
            if (ev.zero) begin
              done          <= 1'b1;
              result.root   <= hi;
              result.status <= ST_ZERO_HIT;
              state         <= S_IDLE;
            end else begin
              fhi_neg <= ev.neg;
              state   <= S_WLO;
            end
          end
        end
        S_WLO: begin
          if (ev.done) begin
            if (ev.zero) begin
              done          <= 1'b1;
              result.root   <= lo;
              result.status <= ST_ZERO_HIT;
              state         <= S_IDLE;
            end else if (ev.neg == fhi_neg) begin
              done          <= 1'b1;
              result.root   <= lo;
              result.status <= ST_NO_BRACKET;
              state         <= S_IDLE;
            end else begin
              flo_neg <= ev.neg;
              first   <= 1'b0;
              state   <= S_WMID;
            end
          end
        end
        S_WMID: begin
          if (ev.done) begin
            if (ev.zero) begin
              done          <= 1'b1;
              result.root   <= mid;
              result.status <= ST_ZERO_HIT;
              state         <= S_IDLE;
            end else begin
              // Keep the half that still has the sign change.
              if (ev.neg != flo_neg) begin
                hi <= mid;
              end else begin
                lo      <= mid;
                flo_neg <= ev.neg;
              end
              state <= S_LOOP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result issued while sequencer still busy");

  a_req_free: assert property (@(posedge clk) disable iff (rst) eval_req |-> !ev.busy)
    else $error("evaluation requested while evaluator busy");

  a_eval_wait: assert property (@(posedge clk) disable iff (rst)
    ev.done |-> (state == S_WHI || state == S_WLO || state == S_WMID))
    else $error("evaluation finished with no one waiting");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_CONVERGED || result.status == ST_ZERO_HIT ||
              result.status == ST_NO_BRACKET))
    else $error("result status out of range");
`endif

endmodule

// File: tb/tb_cubic_bisection_root_core.sv
// Self-checking testbench for the cubic bisection root finder core.
`timescale 1ns / 100ps

module tb_cubic_bisection_root_core;
  import cbr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int END_WAIT    = 500;
  localparam int RANDOM_ITEMS = 1200;
  localparam int ACC_BITS    = 256;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic signed [ACC_BITS-1:0] poly_acc_t;

  typedef struct {
    int                     cfg_sel;
    logic [VALUE_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0] hi;
    bit                     typed;
    logic [VALUE_WIDTH-1:0] root;
    status_t                status;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  in_item_t               operands;
  logic                   done;
  out_item_t              result;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [VALUE_WIDTH-1:0] cfg_data;

  cfg_t      coef_shadow;
  out_item_t pending_roots [$];
  out_item_t want_item;
  int        mismatch_count = 0;
  int        stall_cycles = 0;
  bit        sender_idles = 1'b1;

  // coef_cubic, coef_square, coef_linear, coef_const, width_tolerance, zero_band
  cfg_t dir_cfgs [5] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd66, 16'd0},
    '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'hFFFE_8000, 16'd66, 16'd0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'hFFFF},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'd0},
    '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000, 16'd1, 16'd0}
  };

  dir_row_t dir_rows [23] = '{
    // all-zero cubic after reset: every end is a zero
    '{0, 32'h0000_0000, 32'h0001_0000, 1, 32'h0001_0000, ST_ZERO_HIT},
    '{0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, ST_ZERO_HIT},
    '{0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF, ST_CONVERGED},
    '{0, 32'd100,       32'd166,       1, 32'd100,       ST_CONVERGED},
    '{0, 32'd100,       32'd167,       1, 32'd167,       ST_ZERO_HIT},
    '{0, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, ST_CONVERGED},
    // x - 1.5
    '{1, 32'h0001_8000, 32'h0003_0000, 1, 32'h0001_8000, ST_ZERO_HIT},
    '{1, 32'h0000_0000, 32'h0001_8000, 1, 32'h0001_8000, ST_ZERO_HIT},
    '{1, 32'h0002_0000, 32'h0004_0000, 1, 32'h0002_0000, ST_NO_BRACKET},
    '{1, 32'hFFFC_0000, 32'h0004_0000, 0, 32'h0,         ST_CONVERGED},
    '{1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0,         ST_CONVERGED},
    // extreme coefficients, tolerance zero acts as one
    '{2, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0,         ST_CONVERGED},
    '{2, 32'hFFFF_FFFF, 32'h0000_0001, 0, 32'h0,         ST_CONVERGED},
    '{2, 32'h0000_0000, 32'h7FFF_FFFF, 0, 32'h0,         ST_CONVERGED},
    '{2, 32'd5,         32'hFFFF_FFFB, 1, 32'd5,         ST_CONVERGED},
    '{2, 32'd7,         32'd8,         1, 32'd7,         ST_CONVERGED},
    // opposite extremes, widest tolerance
    '{3, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0,         ST_CONVERGED},
    '{3, 32'hFFFF_0000, 32'h0001_0000, 0, 32'h0,         ST_CONVERGED},
    '{3, 32'h0000_0000, 32'h0000_FFFF, 1, 32'h0,         ST_CONVERGED},
    '{3, 32'h0000_0000, 32'h0001_0000, 0, 32'h0,         ST_CONVERGED},
    // x^3 - x; in the first row the midpoint lands on the root at zero
    '{4, 32'hFFFE_0000, 32'h0002_0000, 1, 32'h0,         ST_ZERO_HIT},
    '{4, 32'h0000_8000, 32'h0003_0000, 0, 32'h0,         ST_CONVERGED},
    '{4, 32'hFFFD_0000, 32'hFFFF_8000, 0, 32'h0,         ST_CONVERGED}
  };

  cubic_bisection_root_core u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact Horner evaluation, scaled by 2^(4*FRAC_BITS).
  function automatic poly_acc_t cubic_at(logic signed [VALUE_WIDTH-1:0] x);
    poly_acc_t acc;
    poly_acc_t term;
    poly_acc_t xs;
    xs = x;
    acc = $signed(coef_shadow.coef_cubic);
    acc = acc * xs;
    term = $signed(coef_shadow.coef_square);
    acc = acc + (term <<< FRAC_BITS);
    acc = acc * xs;
    term = $signed(coef_shadow.coef_linear);
    acc = acc + (term <<< (2 * FRAC_BITS));
    acc = acc * xs;
    term = $signed(coef_shadow.coef_const);
    return acc + (term <<< (3 * FRAC_BITS));
  endfunction

  function automatic bit within_band(poly_acc_t f);
    poly_acc_t mag;
    poly_acc_t lim;
    mag = (f < 0) ? -f : f;
    lim = ACC_BITS'(coef_shadow.zero_band);
    lim = lim <<< (3 * FRAC_BITS);
    return mag <= lim;
  endfunction

  function automatic out_item_t bisect_root(in_item_t it);
    longint    lo;
    longint    hi;
    longint    tol;
    longint    mid;
    poly_acc_t fu;
    poly_acc_t fd;
    poly_acc_t fm;
    out_item_t r;
    lo = $signed(it.interval_low);
    hi = $signed(it.interval_high);
    tol = (coef_shadow.width_tolerance == 0) ? 1 : longint'(coef_shadow.width_tolerance);
    r.root = it.interval_low;
    r.status = ST_CONVERGED;
    while (hi - lo > tol) begin
      fu = cubic_at(hi[VALUE_WIDTH-1:0]);
      fd = cubic_at(lo[VALUE_WIDTH-1:0]);
      if (within_band(fu)) begin
        r.root = hi[VALUE_WIDTH-1:0];
        r.status = ST_ZERO_HIT;
        break;
      end
      if (within_band(fd)) begin
        r.root = lo[VALUE_WIDTH-1:0];
        r.status = ST_ZERO_HIT;
        break;
      end
      if ((fu < 0) == (fd < 0)) begin
        r.root = lo[VALUE_WIDTH-1:0];
        r.status = ST_NO_BRACKET;
        break;
      end
      mid = (lo + hi) >>> 1;
      fm = cubic_at(mid[VALUE_WIDTH-1:0]);
      if (within_band(fm)) begin
        r.root = mid[VALUE_WIDTH-1:0];
        r.status = ST_ZERO_HIT;
        break;
      end
      if ((fm < 0) != (fd < 0)) hi = mid;
      else lo = mid;
      r.root = lo[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [VALUE_WIDTH-1:0] got,
                               logic [VALUE_WIDTH-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [VALUE_WIDTH-1:0] data);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = data;
    @(negedge clk);
  endtask

  task automatic set_registers(cfg_t c);
    write_reg(REG_COEF_CUBIC, c.coef_cubic);
    write_reg(REG_COEF_SQUARE, c.coef_square);
    write_reg(REG_COEF_LINEAR, c.coef_linear);
    write_reg(REG_COEF_CONST, c.coef_const);
    // upper bits of the narrow registers are dropped
    write_reg(REG_WIDTH_TOL, {16'($urandom), c.width_tolerance});
    write_reg(REG_ZERO_BAND, {16'($urandom), c.zero_band});
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    cfg_we = 1'b0;
    coef_shadow = c;
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    while (sender_idles && $urandom_range(0, 99) < 23) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    operands = it;
    do @(posedge clk); while (busy);
    pending_roots.push_back(typed ? want : bisect_root(it));
    @(negedge clk);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_coef(int kind);
    logic [VALUE_WIDTH-1:0] edges [5];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
    case (kind)
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      default: return edges[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    int   shape;
    shape = $urandom_range(0, 5);
    c.coef_cubic = pick_coef(shape > 2 ? 1 : shape);
    c.coef_square = pick_coef(shape > 2 ? 1 : shape);
    c.coef_linear = pick_coef(shape > 2 ? 1 : shape);
    c.coef_const = pick_coef(shape > 2 ? 1 : shape);
    if (shape == 3) begin
      c.coef_cubic = '0;
      c.coef_square = '0;
    end
    if (shape == 4) c.coef_cubic = '0;
    if (shape == 5) c.coef_const = '0;   // a root sits at zero
    case ($urandom_range(0, 4))
      0: c.width_tolerance = 16'd1;
      1: c.width_tolerance = 16'hFFFF;
      2: c.width_tolerance = 16'd0;
      3: c.width_tolerance = 16'($urandom_range(1, 200));
      default: c.width_tolerance = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: c.zero_band = 16'd0;
      1: c.zero_band = 16'hFFFF;
      2: c.zero_band = 16'($urandom_range(1, 64));
      default: c.zero_band = 16'($urandom);
    endcase
    return c;
  endfunction

  function automatic in_item_t random_interval();
    in_item_t it;
    longint   c;
    longint   lo;
    longint   hi;
    int       pick;
    pick = $urandom_range(0, 99);
    c = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    lo = c - longint'($urandom >> $urandom_range(1, 14)) - 1;
    hi = c + longint'($urandom >> $urandom_range(1, 14)) + 1;
    if (pick >= 85) begin
      // narrow, one-sided or reversed
      lo = c + longint'($urandom_range(0, 1 << 24));
      hi = lo + longint'($urandom_range(0, 1 << 22));
      if (pick >= 93) begin
        c = lo;
        lo = hi;
        hi = c;
      end
    end
    if (lo < -(longint'(1) << 31)) lo = -(longint'(1) << 31);
    if (hi > (longint'(1) << 31) - 1) hi = (longint'(1) << 31) - 1;
    it.interval_low = lo[VALUE_WIDTH-1:0];
    it.interval_high = hi[VALUE_WIDTH-1:0];
    if (pick >= 70 && pick < 85) begin
      it.interval_low = $urandom;
      it.interval_high = $urandom;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_roots.size() == 0) begin
        flag_mismatch("result with no item pending", result.root, '0);
      end else begin
        want_item = pending_roots.pop_front();
        if (result.root !== want_item.root)
          flag_mismatch("root", result.root, want_item.root);
        if (result.status !== want_item.status)
          flag_mismatch("status", 32'(result.status), 32'(want_item.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t want;
    int        cur_sel;
    int        sent;
    int        n;
    rst = 1'b1;
    start = 1'b0;
    operands = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    coef_shadow = dir_cfgs[0];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cur_sel = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_sel != cur_sel) begin
        wait_idle();
        set_registers(dir_cfgs[dir_rows[i].cfg_sel]);
        cur_sel = dir_rows[i].cfg_sel;
      end
      it.interval_low = dir_rows[i].lo;
      it.interval_high = dir_rows[i].hi;
      want.root = dir_rows[i].root;
      want.status = dir_rows[i].status;
      send_item(it, dir_rows[i].typed, want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      set_registers(random_settings());
      n = $urandom_range(20, 60);
      repeat (n) begin
        // hold a long stretch with the sender never idling
        sender_idles = !(sent >= 300 && sent < 550);
        send_item(random_interval(), 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (pending_roots.size() != 0)
      flag_mismatch("items left without result", 32'(pending_roots.size()), '0);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
